[rtl/assert_macros.svh]
// assertion macros for the rtl files (included by the top level)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define SOP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// checked on every rising clock edge, also during reset
`define SOP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

[rtl/sop_pkg.sv]
// package: widths, constants, state and command types of the path search
package sop_pkg;

  localparam int unsigned MAX_POINTS_DEF = 8;
  localparam int unsigned COORD_W        = 8;
  localparam int unsigned EXTRA_W        = 8;
  localparam int unsigned LINK_W         = 18;
  localparam int unsigned TOTAL_W        = 21;
  localparam int unsigned D2_W           = 17;
  localparam int unsigned FRAC_SH        = 16;
  localparam int unsigned RAD_W          = 34;
  localparam int unsigned ROOT_W         = 17;
  localparam int unsigned Q_SH           = 8;

  localparam logic [EXTRA_W-1:0] EXTRA_RST = 8'd16;
  localparam logic [TOTAL_W-1:0] TOTAL_ONES = '1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_ONE_RD,
    ST_ONE_SET,
    ST_PRE_RA,
    ST_PRE_RB,
    ST_PRE_SQ,
    ST_PRE_ST,
    ST_PRE_RT,
    ST_SRCH_INIT,
    ST_EV_RD,
    ST_EV_ACC,
    ST_EV_CMP,
    ST_OUT_INIT,
    ST_OUT_RF,
    ST_OUT_RT,
    ST_OUT_SET,
    ST_OUT_WAIT
  } sop_state_e;

  typedef enum logic [2:0] {
    RS_PA,
    RS_PB,
    RS_BF,
    RS_BT,
    RS_ZERO
  } sop_rsel_e;

  typedef struct packed {
    logic      in_rdy;
    logic      load;
    logic      pt_rd;
    sop_rsel_e pt_sel;
    logic      lat_a;
    logic      sq;
    logic      rt_go;
    logic      dist_wr;
    logic      pair_nxt;
    logic      srch_init;
    logic      dist_rd;
    logic      dist_best;
    logic      ev_acc;
    logic      ev_cmp;
    logic      out_init;
    logic      lat_from;
    logic      out_set;
    logic      one_set;
    logic      link_nxt;
  } sop_cmd_t;

  typedef struct packed {
    logic n_one;
    logic pair_last;
    logic k_last;
    logic perm_last;
    logic rt_done;
    logic out_acc;
    logic out_last;
  } sop_sts_t;

endpackage

[rtl/sop_pt_if.sv]
// channel interface for point items
interface sop_pt_if import sop_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic               last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

[rtl/sop_link_if.sv]
// channel interface for link result items
interface sop_link_if import sop_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] from_x;
  logic [COORD_W-1:0] from_y;
  logic [COORD_W-1:0] to_x;
  logic [COORD_W-1:0] to_y;
  logic [LINK_W-1:0]  link_length;
  logic [TOTAL_W-1:0] total_length;
  logic               last_link;

  modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                  output link_length, output total_length, output last_link,
                  input ready);
  modport sink (input valid, input from_x, input from_y, input to_x, input to_y,
                input link_length, input total_length, input last_link,
                output ready);
endinterface

[rtl/sop_cfg_if.sv]
// configuration write channel carrying the link extra
interface sop_cfg_if import sop_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EXTRA_W-1:0] link_extra;

  modport source (output valid, output link_extra, input ready);
  modport sink (input valid, input link_extra, output ready);
endinterface

[rtl/sop_isqrt.sv]
// iterative integer square root, one root bit per cycle
module sop_isqrt import sop_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned REM_W = ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(ROOT_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/sop_ctrl.sv]
// controller: sequences loading, distance table fill, search and output
module sop_ctrl import sop_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  input  sop_sts_t sts_i,
  output sop_cmd_t cmd_o
);

  sop_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = ST_START;
      end
      ST_START:     state_d = sts_i.n_one ? ST_ONE_RD : ST_PRE_RA;
      ST_ONE_RD:    state_d = ST_ONE_SET;
      ST_ONE_SET:   state_d = ST_OUT_WAIT;
      ST_PRE_RA:    state_d = ST_PRE_RB;
      ST_PRE_RB:    state_d = ST_PRE_SQ;
      ST_PRE_SQ:    state_d = ST_PRE_ST;
      ST_PRE_ST:    state_d = ST_PRE_RT;
      ST_PRE_RT: begin
        if (sts_i.rt_done) state_d = sts_i.pair_last ? ST_SRCH_INIT : ST_PRE_RA;
      end
      ST_SRCH_INIT: state_d = ST_EV_RD;
      ST_EV_RD:     state_d = ST_EV_ACC;
      ST_EV_ACC:    state_d = sts_i.k_last ? ST_EV_CMP : ST_EV_RD;
      ST_EV_CMP:    state_d = sts_i.perm_last ? ST_OUT_INIT : ST_EV_RD;
      ST_OUT_INIT:  state_d = ST_OUT_RF;
      ST_OUT_RF:    state_d = ST_OUT_RT;
      ST_OUT_RT:    state_d = ST_OUT_SET;
      ST_OUT_SET:   state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (sts_i.out_acc) state_d = sts_i.out_last ? ST_IDLE : ST_OUT_RF;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.pt_sel = RS_PA;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_rdy = 1'b1;
        cmd_o.load   = in_valid_i;
      end
      ST_ONE_RD: begin
        cmd_o.pt_rd  = 1'b1;
        cmd_o.pt_sel = RS_ZERO;
      end
      ST_ONE_SET: cmd_o.one_set = 1'b1;
      ST_PRE_RA: begin
        cmd_o.pt_rd  = 1'b1;
        cmd_o.pt_sel = RS_PA;
      end
      ST_PRE_RB: begin
        cmd_o.lat_a  = 1'b1;
        cmd_o.pt_rd  = 1'b1;
        cmd_o.pt_sel = RS_PB;
      end
      ST_PRE_SQ: cmd_o.sq = 1'b1;
      ST_PRE_ST: cmd_o.rt_go = 1'b1;
      ST_PRE_RT: begin
        cmd_o.dist_wr  = sts_i.rt_done;
        cmd_o.pair_nxt = sts_i.rt_done;
      end
      ST_SRCH_INIT: cmd_o.srch_init = 1'b1;
      ST_EV_RD:     cmd_o.dist_rd = 1'b1;
      ST_EV_ACC:    cmd_o.ev_acc = 1'b1;
      ST_EV_CMP:    cmd_o.ev_cmp = 1'b1;
      ST_OUT_INIT:  cmd_o.out_init = 1'b1;
      ST_OUT_RF: begin
        cmd_o.pt_rd  = 1'b1;
        cmd_o.pt_sel = RS_BF;
      end
      ST_OUT_RT: begin
        cmd_o.lat_from  = 1'b1;
        cmd_o.pt_rd     = 1'b1;
        cmd_o.pt_sel    = RS_BT;
        cmd_o.dist_rd   = 1'b1;
        cmd_o.dist_best = 1'b1;
      end
      ST_OUT_SET:  cmd_o.out_set = 1'b1;
      ST_OUT_WAIT: cmd_o.link_nxt = sts_i.out_acc && !sts_i.out_last;
      default: begin
        cmd_o.in_rdy = 1'b0;
      end
    endcase
  end

endmodule

[rtl/sop_dp.sv]
// datapath: point store, distance table, order registers and result register
module sop_dp import sop_pkg::*; #(
  parameter int unsigned MaxPoints = MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sop_cmd_t           cmd_i,
  output sop_sts_t           sts_o,
  input  logic [COORD_W-1:0] pt_x_i,
  input  logic [COORD_W-1:0] pt_y_i,
  input  logic               pt_last_i,
  input  logic               cfg_valid_i,
  input  logic [EXTRA_W-1:0] cfg_extra_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [COORD_W-1:0] from_x_o,
  output logic [COORD_W-1:0] from_y_o,
  output logic [COORD_W-1:0] to_x_o,
  output logic [COORD_W-1:0] to_y_o,
  output logic [LINK_W-1:0]  link_length_o,
  output logic [TOTAL_W-1:0] total_length_o,
  output logic               last_link_o
);

  localparam int unsigned IdxW  = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW  = $clog2(MaxPoints + 1) + 1;
  localparam int unsigned DAW   = 2 * IdxW;
  localparam int unsigned PT_W  = 2 * COORD_W;

  // memories
  logic [PT_W-1:0]   pt_mem   [MaxPoints];
  logic [LINK_W-1:0] dist_mem [1 << DAW];
  logic [PT_W-1:0]   pt_rdata_q;
  logic [LINK_W-1:0] dist_rdata_q;

  // control registers
  logic [CntW-1:0]    cnt_q, n_q;
  logic [IdxW-1:0]    pa_q, pb_q, k_q;
  logic [IdxW-1:0]    trial_q [MaxPoints];
  logic [IdxW-1:0]    best_q  [MaxPoints];
  logic               out_valid_q;

  // payload registers
  logic [EXTRA_W-1:0] extra_q;
  logic [PT_W-1:0]    pa_pt_q;
  logic [D2_W-1:0]    d2_q;
  logic [TOTAL_W-1:0] acc_q, best_tot_q, tot_q;
  logic [COORD_W-1:0] from_x_q, from_y_q, to_x_q, to_y_q;
  logic [LINK_W-1:0]  len_q;
  logic               last_q;

  logic [IdxW-1:0]    pt_raddr;
  logic [DAW-1:0]     dist_raddr;
  logic [IdxW-1:0]    n_m1;
  logic [IdxW-1:0]    k_p1;
  logic               k_last;
  logic               pt_full;
  logic [COORD_W-1:0] dx, dy;
  logic [D2_W-1:0]    d2_d;
  logic               rt_done;
  logic [ROOT_W-1:0]  root;
  logic [LINK_W-1:0]  link_len;
  logic [TOTAL_W-1:0] acc_sum;

  // next permutation lanes
  logic [MaxPoints-1:0] desc;
  logic [IdxW-1:0]      ipos, jpos;
  logic [IdxW-1:0]      piv;
  logic [IdxW-1:0]      perm_nxt [MaxPoints];
  int                   m;

  assign n_m1    = IdxW'(n_q - CntW'(1));
  assign k_p1    = IdxW'(k_q + IdxW'(1));
  assign k_last  = ((CntW'(k_q) + CntW'(2)) == n_q);
  assign pt_full = (cnt_q == CntW'(MaxPoints));

  sop_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.rt_go),
    .rad_i   (RAD_W'({d2_q, FRAC_SH'(0)})),
    .done_o  (rt_done),
    .root_o  (root)
  );

  assign link_len = LINK_W'(root) + (LINK_W'(extra_q) << Q_SH);

  always_comb begin
    case (cmd_i.pt_sel)
      RS_PA:   pt_raddr = pa_q;
      RS_PB:   pt_raddr = pb_q;
      RS_BF:   pt_raddr = best_q[k_q];
      RS_BT:   pt_raddr = best_q[k_p1];
      default: pt_raddr = '0;
    endcase
  end

  assign dist_raddr = cmd_i.dist_best ? {best_q[k_q], best_q[k_p1]}
                                      : {trial_q[k_q], trial_q[k_p1]};

  assign dx   = (pa_pt_q[COORD_W-1:0] > pt_rdata_q[COORD_W-1:0])
              ? pa_pt_q[COORD_W-1:0] - pt_rdata_q[COORD_W-1:0]
              : pt_rdata_q[COORD_W-1:0] - pa_pt_q[COORD_W-1:0];
  assign dy   = (pa_pt_q[PT_W-1:COORD_W] > pt_rdata_q[PT_W-1:COORD_W])
              ? pa_pt_q[PT_W-1:COORD_W] - pt_rdata_q[PT_W-1:COORD_W]
              : pt_rdata_q[PT_W-1:COORD_W] - pa_pt_q[PT_W-1:COORD_W];
  assign d2_d = D2_W'(dx) * D2_W'(dx) + D2_W'(dy) * D2_W'(dy);

  assign acc_sum = acc_q + TOTAL_W'(dist_rdata_q);

  // lexicographic successor of the trial order over the first n lanes
  always_comb begin
    desc = '0;
    ipos = '0;
    jpos = '0;
    for (int k = 1; k < MaxPoints; k++) begin
      desc[k] = (k < int'(n_q)) && (trial_q[k-1] < trial_q[k]);
      if (desc[k]) ipos = IdxW'(k - 1);
    end
    piv = trial_q[ipos];
    for (int k = 0; k < MaxPoints; k++) begin
      if ((k < int'(n_q)) && (trial_q[k] > piv)) jpos = IdxW'(k);
    end
    for (int k = 0; k < MaxPoints; k++) begin
      m = int'(n_q) - 1 + int'(ipos) + 1 - k;
      if (k < int'(ipos)) begin
        perm_nxt[k] = trial_q[k];
      end else if (k == int'(ipos)) begin
        perm_nxt[k] = trial_q[jpos];
      end else if (k < int'(n_q)) begin
        // suffix reversed after the swap
        perm_nxt[k] = (m == int'(jpos)) ? piv : trial_q[IdxW'(m)];
      end else begin
        perm_nxt[k] = trial_q[k];
      end
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !pt_full) begin
      pt_mem[IdxW'(cnt_q)] <= {pt_y_i, pt_x_i};
    end
    if (cmd_i.pt_rd) begin
      pt_rdata_q <= pt_mem[pt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dist_wr) begin
      dist_mem[{pa_q, pb_q}] <= link_len;
    end
    if (cmd_i.dist_rd) begin
      dist_rdata_q <= dist_mem[dist_raddr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      n_q         <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      extra_q     <= EXTRA_RST;
      for (int k = 0; k < MaxPoints; k++) begin
        trial_q[k] <= IdxW'(k);
      end
    end else begin
      if (cfg_valid_i) extra_q <= cfg_extra_i;
      if (cmd_i.load) begin
        if (pt_last_i) begin
          cnt_q <= '0;
          n_q   <= pt_full ? cnt_q : cnt_q + CntW'(1);
          pa_q  <= '0;
          pb_q  <= '0;
        end else if (!pt_full) begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (cmd_i.pair_nxt) begin
        if (pb_q == n_m1) begin
          pb_q <= '0;
          pa_q <= pa_q + IdxW'(1);
        end else begin
          pb_q <= pb_q + IdxW'(1);
        end
      end
      if (cmd_i.srch_init) begin
        k_q <= '0;
        for (int k = 0; k < MaxPoints; k++) begin
          trial_q[k] <= IdxW'(k);
        end
      end
      if (cmd_i.ev_acc || cmd_i.link_nxt) k_q <= k_p1;
      if (cmd_i.ev_cmp) begin
        k_q <= '0;
        if (|desc) begin
          for (int k = 0; k < MaxPoints; k++) begin
            trial_q[k] <= perm_nxt[k];
          end
        end
      end
      if (cmd_i.out_init) k_q <= '0;
      if (cmd_i.out_set || cmd_i.one_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_a) pa_pt_q <= pt_rdata_q;
    if (cmd_i.sq) d2_q <= d2_d;
    if (cmd_i.srch_init) begin
      acc_q      <= '0;
      best_tot_q <= TOTAL_ONES;
    end
    if (cmd_i.ev_acc) acc_q <= acc_sum;
    if (cmd_i.ev_cmp) begin
      acc_q <= '0;
      if (acc_q < best_tot_q) begin
        best_tot_q <= acc_q;
        for (int k = 0; k < MaxPoints; k++) begin
          best_q[k] <= trial_q[k];
        end
      end
    end
    if (cmd_i.out_init) tot_q <= '0;
    if (cmd_i.lat_from) begin
      from_x_q <= pt_rdata_q[COORD_W-1:0];
      from_y_q <= pt_rdata_q[PT_W-1:COORD_W];
    end
    if (cmd_i.out_set) begin
      to_x_q <= pt_rdata_q[COORD_W-1:0];
      to_y_q <= pt_rdata_q[PT_W-1:COORD_W];
      len_q  <= dist_rdata_q;
      tot_q  <= tot_q + TOTAL_W'(dist_rdata_q);
      last_q <= k_last;
    end
    if (cmd_i.one_set) begin
      from_x_q <= pt_rdata_q[COORD_W-1:0];
      from_y_q <= pt_rdata_q[PT_W-1:COORD_W];
      to_x_q   <= pt_rdata_q[COORD_W-1:0];
      to_y_q   <= pt_rdata_q[PT_W-1:COORD_W];
      len_q    <= '0;
      tot_q    <= '0;
      last_q   <= 1'b1;
    end
  end

  assign sts_o.n_one     = (n_q == CntW'(1));
  assign sts_o.pair_last = (pa_q == n_m1) && (pb_q == n_m1);
  assign sts_o.k_last    = k_last;
  assign sts_o.perm_last = ~|desc;
  assign sts_o.rt_done   = rt_done;
  assign sts_o.out_acc   = out_valid_q && out_ready_i;
  assign sts_o.out_last  = last_q;

  assign out_valid_o    = out_valid_q;
  assign from_x_o       = from_x_q;
  assign from_y_o       = from_y_q;
  assign to_x_o         = to_x_q;
  assign to_y_o         = to_y_q;
  assign link_length_o  = len_q;
  assign total_length_o = tot_q;
  assign last_link_o    = last_q;

endmodule

[rtl/shortest_open_path_search_core.sv]
// top level: brute force shortest open path over up to MaxPoints points
//
//   channel  dir  handshake     payload
//   pt_i     in   valid/ready   point_x, point_y, last_point
//   link_o   out  valid/ready   from_x/y, to_x/y, link_length, total_length, last_link
//   cfg_i    in   valid/ready   link_extra (always ready)
//
// points load one item per cycle while idle; the item marked last starts the search
// distance table fill: n*n pairs, each read, squared, rooted and written, sqrt unit one bit a cycle
// search: n! orders, one distance table read per link, then a compare of the order total
// output: per link, read the from and to points, set the item, then wait on link_o.ready; no clearing pass after reset
// pt_i is not ready from the last point until the final link item is taken
`include "assert_macros.svh"

module shortest_open_path_search_core import sop_pkg::*; #(
  parameter int unsigned MaxPoints = MAX_POINTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sop_pt_if.sink     pt_i,
  sop_link_if.source link_o,
  sop_cfg_if.sink    cfg_i
);

  sop_cmd_t cmd;
  sop_sts_t sts;

  assign pt_i.ready  = cmd.in_rdy;
  assign cfg_i.ready = 1'b1;

  sop_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pt_i.valid),
    .in_last_i  (pt_i.last_point),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sop_dp #(
    .MaxPoints (MaxPoints)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pt_x_i         (pt_i.point_x),
    .pt_y_i         (pt_i.point_y),
    .pt_last_i      (pt_i.last_point),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_extra_i    (cfg_i.link_extra),
    .out_ready_i    (link_o.ready),
    .out_valid_o    (link_o.valid),
    .from_x_o       (link_o.from_x),
    .from_y_o       (link_o.from_y),
    .to_x_o         (link_o.to_x),
    .to_y_o         (link_o.to_y),
    .link_length_o  (link_o.link_length),
    .total_length_o (link_o.total_length),
    .last_link_o    (link_o.last_link)
  );

  // points are only taken with no result pending
  `SOP_ASSERT(a_no_load_while_out, pt_i.ready |-> !link_o.valid)
  // running total never falls below the link it includes
  `SOP_ASSERT(a_total_covers_link, link_o.valid |-> (link_o.total_length >= link_o.link_length))
  // after the final link item the block is back to loading
  `SOP_ASSERT(a_idle_after_last, (link_o.valid && link_o.ready && link_o.last_link) |=> pt_i.ready)
  // during reset nothing is offered
  `SOP_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !link_o.valid)

endmodule

[sim/tb_shortest_open_path_search_core.sv]
// testbench: random and directed point sets against a brute force path predictor
module tb_shortest_open_path_search_core;
  import sop_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    logic [LINK_W-1:0]  len;
    logic [TOTAL_W-1:0] tot;
    logic               last;
  } link_t;

  class path_scoreboard;
    link_t                links_due[$];
    logic  [EXTRA_W-1:0]  extra;
    logic  [15:0]         pts[8];
    int                   npts;
    int                   errors;

    function new();
      extra = EXTRA_RST;
      npts = 0;
      errors = 0;
    endfunction

    function automatic logic [LINK_W-1:0] link_len(int a, int b);
      longint unsigned v, r, bt;
      int dx, dy;
      dx = int'(pts[a][7:0]) - int'(pts[b][7:0]);
      dy = int'(pts[a][15:8]) - int'(pts[b][15:8]);
      v = longint'(dx * dx + dy * dy) << 16;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= r + bt) begin
          v -= r + bt;
          r = (r >> 1) + bt;
        end else begin
          r >>= 1;
        end
        bt >>= 2;
      end
      return LINK_W'(r + (longint'(extra) << Q_SH));
    endfunction

    function void note_point(logic [7:0] x, logic [7:0] y, logic lastp);
      int n, i, j, k;
      int ord[8], best[8];
      logic [TOTAL_W-1:0] tot, best_tot;
      link_t l;
      if (npts < 8) begin
        pts[npts] = {y, x};
        npts++;
      end
      if (!lastp) return;
      n = npts;
      npts = 0;
      if (n == 1) begin
        links_due.push_back({pts[0][7:0], pts[0][15:8], pts[0][7:0], pts[0][15:8],
                             {LINK_W{1'b0}}, {TOTAL_W{1'b0}}, 1'b1});
        return;
      end
      for (i = 0; i < n; i++) ord[i] = i;
      best_tot = TOTAL_ONES;
      forever begin
        tot = 0;
        for (i = 0; i + 1 < n; i++) tot += link_len(ord[i], ord[i+1]);
        if (tot < best_tot) begin
          best_tot = tot;
          best = ord;
        end
        // next order in lexicographic sequence
        i = n - 1;
        while (i > 0 && ord[i-1] >= ord[i]) i--;
        if (i == 0) break;
        i--;
        j = n - 1;
        while (ord[j] <= ord[i]) j--;
        k = ord[i]; ord[i] = ord[j]; ord[j] = k;
        for (j = n - 1, i = i + 1; i < j; i++, j--) begin
          k = ord[i]; ord[i] = ord[j]; ord[j] = k;
        end
      end
      tot = 0;
      for (i = 0; i + 1 < n; i++) begin
        l.fx = pts[best[i]][7:0];
        l.fy = pts[best[i]][15:8];
        l.tx = pts[best[i+1]][7:0];
        l.ty = pts[best[i+1]][15:8];
        l.len = link_len(best[i], best[i+1]);
        tot += l.len;
        l.tot = tot;
        l.last = (i + 2 == n);
        links_due.push_back(l);
      end
    endfunction

    function void check_link(link_t got);
      link_t want;
      if (links_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected link item %h", got);
        return;
      end
      want = links_due.pop_front();
      if (got.fx !== want.fx || got.fy !== want.fy || got.tx !== want.tx ||
          got.ty !== want.ty || got.len !== want.len || got.tot !== want.tot ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"link mismatch: exp (%0d,%0d)->(%0d,%0d) len %0d tot %0d last %0d,",
                    " got (%0d,%0d)->(%0d,%0d) len %0d tot %0d last %0d"},
                   want.fx, want.fy, want.tx, want.ty, want.len, want.tot, want.last,
                   got.fx, got.fy, got.tx, got.ty, got.len, got.tot, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  sop_pt_if   pt();
  sop_link_if lk();
  sop_cfg_if  cfg();
  path_scoreboard sb;
  bit hold_req;
  int idle_cycles;

  shortest_open_path_search_core dut (
    .clk_i(clk), .rst_ni(rst_n), .pt_i(pt), .link_o(lk), .cfg_i(cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    pt.valid = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    pt.last_point = 1'b0;
    lk.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.link_extra = '0;
    rst_n = 1'b0;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // no handshake for too long means a hang
  always @(posedge clk) begin
    if ((pt.valid && pt.ready) || (lk.valid && lk.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial idle_cycles = 0;

  // link receiver
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        lk.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        lk.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      lk.ready <= 1'b1;
      do @(posedge clk); while (!lk.valid);
      sb.check_link({lk.from_x, lk.from_y, lk.to_x, lk.to_y,
                     lk.link_length, lk.total_length, lk.last_link});
    end
  end

  task automatic send_point(logic [7:0] x, logic [7:0] y, logic lastp, bit nogap = 0);
    int gap;
    gap = (nogap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      pt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt.valid <= 1'b1;
    pt.point_x <= x;
    pt.point_y <= y;
    pt.last_point <= lastp;
    do @(posedge clk); while (!pt.ready);
    sb.note_point(x, y, lastp);
  endtask

  task automatic write_extra(logic [7:0] v);
    pt.valid <= 1'b0;
    while (sb.links_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.link_extra <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.extra = v;
  endtask

  task automatic send_random_set(bit clustered, output int cnt);
    int n;
    n = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      if (clustered)
        send_point(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), i == n - 1);
      else
        send_point(8'($urandom), 8'($urandom), i == n - 1);
    end
    cnt = n;
  endtask

  initial begin
    int sent;
    int got;
    hold_req = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    @(posedge clk);
    // single point, extreme pair, then an overfull set of nine
    send_point(8'd255, 8'd0, 1'b1);
    send_point(8'd0, 8'd0, 1'b0);
    send_point(8'd255, 8'd255, 1'b1);
    for (int i = 0; i < 9; i++)
      send_point(8'(i * 31), 8'(255 - i * 29), i == 8);
    // let results back up while the next set is offered
    hold_req = 1'b1;
    send_point(8'd1, 8'd2, 1'b0, 1);
    send_point(8'd3, 8'd4, 1'b0, 1);
    send_point(8'd170, 8'd85, 1'b1, 1);
    // equal-length links to exercise ties
    send_point(8'd0, 8'd0, 1'b0);
    send_point(8'd0, 8'd1, 1'b0);
    send_point(8'd1, 8'd0, 1'b0);
    send_point(8'd1, 8'd1, 1'b1);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_extra(8'd255);
        1: write_extra(8'd0);
        default: write_extra(8'($urandom));
      endcase
      sent = 0;
      while (sent < 110) begin
        send_random_set($urandom_range(0, 4) == 0, got);
        sent = sent + got;
      end
    end
    pt.valid <= 1'b0;
    while (sb.links_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.links_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
